[hdl/mbrtu_pkg.sv]
// Shared types and constants of the Modbus RTU slave frame engine.
// No dependencies; the top level and the bench import this package.
`default_nettype none

package mbrtu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 2'd1;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd1500;

    localparam logic [2:0] CMD_RX_BYTE = 3'd0;
    localparam logic [2:0] CMD_GAP     = 3'd1;
    localparam logic [2:0] CMD_PUSH    = 3'd2;
    localparam logic [2:0] CMD_ANSWER  = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_REQUEST = 3'd1;
    localparam logic [2:0] EV_TX_BYTE = 3'd2;
    localparam logic [2:0] EV_BAD_PUSH = 3'd3;
    localparam logic [2:0] EV_DROP    = 3'd4;

    localparam logic [1:0] KIND_READ         = 2'd0;
    localparam logic [1:0] KIND_WRITE_SINGLE = 2'd1;
    localparam logic [1:0] KIND_WRITE_MULTI  = 2'd2;
    localparam logic [1:0] KIND_READ_WRITE   = 2'd3;

    localparam logic [7:0] FN_READ         = 8'h03;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;
    localparam logic [7:0] FN_READ_WRITE   = 8'h17;

    localparam logic [7:0]  BROADCAST_ADDR = 8'hFE;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam int          MIN_FRAME      = 6;
    localparam logic [8:0]  MAX_REPLY      = 9'd253;
    localparam logic [8:0]  LEN_SAT        = 9'd511;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  request_kind;
        logic [15:0] read_start;
        logic [7:0]  read_count;
        logic [15:0] write_start;
        logic [7:0]  write_count;
        logic [7:0]  tx_byte;
        logic        tx_last;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/mbrtu_if.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on nothing; used by the top level of the frame engine.
`default_nettype none

interface mbrtu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [15:0] reg_addr;
    logic [15:0] reg_data;
    logic        tx_ready;

    modport source (output valid, cmd, byte_value, reg_addr, reg_data, tx_ready, input ready);
    modport sink (input valid, cmd, byte_value, reg_addr, reg_data, tx_ready, output ready);
endinterface

interface mbrtu_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  request_kind;
    logic [15:0] read_start;
    logic [7:0]  read_count;
    logic [15:0] write_start;
    logic [7:0]  write_count;
    logic [7:0]  tx_byte;
    logic        tx_last;

    modport source (output valid, event_res, request_kind, read_start, read_count,
                    write_start, write_count, tx_byte, tx_last, input ready);
    modport sink (input valid, event_res, request_kind, read_start, read_count,
                  write_start, write_count, tx_byte, tx_last, output ready);
endinterface

`default_nettype wire

[hdl/mbrtu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mbrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/modbus_rtu_slave_frame_engine_top.sv]
// Top level of the Modbus RTU slave frame engine.
// Depends on mbrtu_pkg, mbrtu_if.sv and mbrtu_ram.
//
// Usage: request beats arrive on req (received byte, frame gap, read word push,
// answer, tick or transmitter ready) and each yields exactly one result beat
// on rsp. The frame CRC is accumulated as bytes arrive, so the frame check at
// the gap is a single step. The reply CRC is accumulated while the reply is
// sent and its two bytes are emitted after the stored bytes.
// A result beat is presented in the cycle after its request is accepted; a new
// request is accepted in every cycle unless rsp stalls; the reply buffer is two
// banks of 128 bytes with a registered read addressed ahead of the byte sent.
// The result is held in an output register: while rsp is stalled, one further
// request is taken only once the held beat has left.
// Reset returns the block to waiting for the first byte of a frame with slave address 1
// and an answer timeout of 1500 ticks. Configuration writes on the cfg port take effect
// at once; the user must make them while no request is in flight, as the block does not check.
`default_nettype none

module modbus_rtu_slave_frame_engine_top #(
    parameter int FRAME_BYTES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mbrtu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mbrtu_pkg::CFG_DATA_W-1:0]   cfg_data,
    mbrtu_req_if.sink                               req,
    mbrtu_rsp_if.source                             rsp
);

    import mbrtu_pkg::*;

    localparam int CntW = $clog2(FRAME_BYTES + 2);
    localparam int HeadBytes = 10;
    localparam int HdrBytes = 6;

    localparam logic [1:0] PH_WAIT_FIRST = 2'd0;
    localparam logic [1:0] PH_RECEIVE    = 2'd1;
    localparam logic [1:0] PH_AWAIT      = 2'd2;
    localparam logic [1:0] PH_TRANSMIT   = 2'd3;

    logic [7:0]      slave_addr_reg;
    logic [15:0]     timeout_reg;
    logic [1:0]      phase_reg, phase_next;
    logic [CntW-1:0] rx_count_reg, rx_count_next;
    logic [7:0]      head_reg [0:HeadBytes-1];
    logic [7:0]      head_next [0:HeadBytes-1];
    logic [7:0]      last1_reg, last1_next, last2_reg, last2_next;
    logic [15:0]     crc0_reg, crc0_next, crc1_reg, crc1_next, crc2_reg, crc2_next;
    logic [7:0]      hdr_reg [0:HdrBytes-1];
    logic [7:0]      hdr_next [0:HdrBytes-1];
    logic [8:0]      len_reg, len_next;
    logic [7:0]      pos_reg, pos_next;
    logic [15:0]     saved_rs_reg, saved_rs_next;
    logic [7:0]      saved_fn_reg, saved_fn_next;
    logic [15:0]     timer_reg, timer_next;
    logic [15:0]     txcrc_reg, txcrc_next;
    logic            rsp_valid_reg;
    result_t         res_reg, res_next;

    logic            fire;
    logic            odd_we, even_we;
    logic [6:0]      odd_waddr, even_waddr;
    logic [7:0]      odd_wdata, even_wdata, odd_rdata, even_rdata;

    logic [7:0]      hv [0:HeadBytes-1];
    logic            first_byte;
    logic [CntW-1:0] c_eff;
    logic [15:0]     crc_base;
    logic            frame_ok;
    logic [15:0]     diff;
    logic [6:0]      d1, d2;
    logic [7:0]      k_odd, k_even;
    logic [7:0]      tx_len8;
    logic [7:0]      cur_byte;
    logic [7:0]      stored_byte;

    assign fire      = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        for (int i = 0; i < HeadBytes; i++)
        begin
            hv[i] = (CntW'(i) < rx_count_reg) ? head_reg[i] : 8'h00;
        end
    end

    assign frame_ok = (rx_count_reg >= CntW'(MIN_FRAME))
                   && (rx_count_reg <= CntW'(FRAME_BYTES))
                   && ((hv[0] == slave_addr_reg) || (hv[0] == BROADCAST_ADDR))
                   && (crc2_reg == {last1_reg, last2_reg});

    assign diff   = req.reg_addr - saved_rs_reg;
    assign d1     = diff[6:0] + 7'd1;
    assign d2     = diff[6:0] + 7'd2;
    assign k_odd  = {d1, 1'b1};
    assign k_even = {d2, 1'b0};

    assign tx_len8     = len_reg[7:0];
    assign stored_byte = (pos_reg < 8'(HdrBytes)) ? hdr_reg[pos_reg[2:0]]
                       : (pos_reg[0] ? odd_rdata : even_rdata);
    assign cur_byte    = (pos_reg < tx_len8) ? stored_byte
                       : ((pos_reg == tx_len8) ? txcrc_reg[7:0] : txcrc_reg[15:8]);

    assign first_byte = (phase_reg == PH_WAIT_FIRST);
    assign c_eff      = first_byte ? '0 : rx_count_reg;
    assign crc_base   = first_byte ? CRC_INIT : crc0_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        rx_count_next = rx_count_reg;
        head_next     = head_reg;
        last1_next    = last1_reg;
        last2_next    = last2_reg;
        crc0_next     = crc0_reg;
        crc1_next     = crc1_reg;
        crc2_next     = crc2_reg;
        hdr_next      = hdr_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        saved_rs_next = saved_rs_reg;
        saved_fn_next = saved_fn_reg;
        timer_next    = timer_reg;
        txcrc_next    = txcrc_reg;
        res_next      = '0;
        odd_we        = 1'b0;
        even_we       = 1'b0;
        odd_waddr     = d1;
        even_waddr    = d2;
        odd_wdata     = req.reg_data[15:8];
        even_wdata    = req.reg_data[7:0];

        if (fire)
        begin
            case (req.cmd)
                CMD_RX_BYTE:
                begin
                    if (phase_reg == PH_WAIT_FIRST || phase_reg == PH_RECEIVE)
                    begin
                        phase_next = PH_RECEIVE;
                        if (c_eff < CntW'(FRAME_BYTES))
                        begin
                            if (c_eff < CntW'(HeadBytes))
                            begin
                                head_next[c_eff[3:0]] = req.byte_value;
                            end
                            last2_next    = last1_reg;
                            last1_next    = req.byte_value;
                            crc2_next     = crc1_reg;
                            crc1_next     = crc_base;
                            crc0_next     = crc_update(crc_base, req.byte_value);
                            rx_count_next = c_eff + CntW'(1);
                        end
                        else
                        begin
                            rx_count_next = CntW'(FRAME_BYTES + 1);
                        end
                    end
                end
                CMD_GAP:
                begin
                    if (phase_reg == PH_RECEIVE)
                    begin
                        phase_next = PH_WAIT_FIRST;
                        if (frame_ok)
                        begin
                            hdr_next[0] = slave_addr_reg;
                            hdr_next[1] = hv[1];
                            if (hv[1] == FN_READ || hv[1] == FN_READ_WRITE)
                            begin
                                hdr_next[2]          = {hv[5][6:0], 1'b0};
                                len_next             = 9'd3;
                                saved_rs_next        = {hv[2], hv[3]};
                                saved_fn_next        = hv[1];
                                timer_next           = timeout_reg;
                                phase_next           = PH_AWAIT;
                                res_next.event_res   = EV_REQUEST;
                                res_next.read_start  = {hv[2], hv[3]};
                                res_next.read_count  = hv[5];
                                if (hv[1] == FN_READ_WRITE)
                                begin
                                    res_next.request_kind = KIND_READ_WRITE;
                                    res_next.write_start  = {hv[6], hv[7]};
                                    res_next.write_count  = hv[9];
                                end
                                else
                                begin
                                    res_next.request_kind = KIND_READ;
                                end
                            end
                            else if (hv[1] == FN_WRITE_SINGLE || hv[1] == FN_WRITE_MULTI)
                            begin
                                for (int i = 2; i < HdrBytes; i++)
                                begin
                                    hdr_next[i] = hv[i];
                                end
                                len_next             = 9'd6;
                                saved_fn_next        = hv[1];
                                timer_next           = timeout_reg;
                                phase_next           = PH_AWAIT;
                                res_next.event_res   = EV_REQUEST;
                                res_next.write_start = {hv[2], hv[3]};
                                if (hv[1] == FN_WRITE_SINGLE)
                                begin
                                    res_next.request_kind = KIND_WRITE_SINGLE;
                                    res_next.write_count  = 8'd1;
                                end
                                else
                                begin
                                    res_next.request_kind = KIND_WRITE_MULTI;
                                    res_next.write_count  = hv[5];
                                end
                            end
                        end
                    end
                end
                CMD_PUSH:
                begin
                    if (phase_reg != PH_AWAIT || req.reg_addr < saved_rs_reg
                        || (saved_fn_reg != FN_READ && saved_fn_reg != FN_READ_WRITE))
                    begin
                        res_next.event_res = EV_BAD_PUSH;
                    end
                    else
                    begin
                        odd_we  = 1'b1;
                        even_we = 1'b1;
                        if (k_odd < 8'(HdrBytes))
                        begin
                            hdr_next[k_odd[2:0]] = req.reg_data[15:8];
                        end
                        if (k_even < 8'(HdrBytes))
                        begin
                            hdr_next[k_even[2:0]] = req.reg_data[7:0];
                        end
                        len_next = (len_reg >= LEN_SAT - 9'd2) ? LEN_SAT : len_reg + 9'd2;
                    end
                end
                CMD_ANSWER:
                begin
                    if (phase_reg == PH_AWAIT)
                    begin
                        if (len_reg > MAX_REPLY)
                        begin
                            res_next.event_res = EV_DROP;
                            phase_next         = PH_WAIT_FIRST;
                        end
                        else
                        begin
                            txcrc_next = CRC_INIT;
                            pos_next   = 8'd0;
                            phase_next = PH_TRANSMIT;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (phase_reg == PH_AWAIT)
                    begin
                        if (timer_reg <= 16'd1)
                        begin
                            timer_next         = 16'd0;
                            res_next.event_res = EV_DROP;
                            phase_next         = PH_WAIT_FIRST;
                        end
                        else
                        begin
                            timer_next = timer_reg - 16'd1;
                        end
                    end
                    else if (phase_reg == PH_TRANSMIT && req.tx_ready)
                    begin
                        res_next.event_res = EV_TX_BYTE;
                        res_next.tx_byte   = cur_byte;
                        if ({1'b0, pos_reg} + 9'd1 >= len_reg + 9'd2)
                        begin
                            res_next.tx_last = 1'b1;
                            phase_next       = PH_WAIT_FIRST;
                        end
                        if (pos_reg < tx_len8)
                        begin
                            txcrc_next = crc_update(txcrc_reg, cur_byte);
                        end
                        else
                        begin
                            if (pos_reg < 8'(HdrBytes))
                            begin
                                hdr_next[pos_reg[2:0]] = cur_byte;
                            end
                            odd_waddr  = pos_reg[7:1];
                            even_waddr = pos_reg[7:1];
                            odd_wdata  = cur_byte;
                            even_wdata = cur_byte;
                            odd_we     = pos_reg[0];
                            even_we    = !pos_reg[0];
                        end
                        pos_next = pos_reg + 8'd1;
                    end
                end
                default:
                begin
                    res_next.event_res = EV_NONE;
                end
            endcase
        end
    end

    mbrtu_ram #(.WIDTH(8), .DEPTH(128)) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .raddr (pos_next[7:1]),
        .rdata (odd_rdata)
    );

    mbrtu_ram #(.WIDTH(8), .DEPTH(128)) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .raddr (pos_next[7:1]),
        .rdata (even_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            phase_reg      <= PH_WAIT_FIRST;
            rx_count_reg   <= '0;
            crc0_reg       <= CRC_INIT;
            crc1_reg       <= CRC_INIT;
            crc2_reg       <= CRC_INIT;
            len_reg        <= '0;
            pos_reg        <= '0;
            saved_rs_reg   <= '0;
            saved_fn_reg   <= '0;
            timer_reg      <= '0;
            txcrc_reg      <= CRC_INIT;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                    CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                    default:        ;
                endcase
            end
            phase_reg     <= phase_next;
            rx_count_reg  <= rx_count_next;
            crc0_reg      <= crc0_next;
            crc1_reg      <= crc1_next;
            crc2_reg      <= crc2_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            saved_rs_reg  <= saved_rs_next;
            saved_fn_reg  <= saved_fn_next;
            timer_reg     <= timer_next;
            txcrc_reg     <= txcrc_next;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        hdr_reg   <= hdr_next;
        last1_reg <= last1_next;
        last2_reg <= last2_next;
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.event_res    = res_reg.event_res;
    assign rsp.request_kind = res_reg.request_kind;
    assign rsp.read_start   = res_reg.read_start;
    assign rsp.read_count   = res_reg.read_count;
    assign rsp.write_start  = res_reg.write_start;
    assign rsp.write_count  = res_reg.write_count;
    assign rsp.tx_byte      = res_reg.tx_byte;
    assign rsp.tx_last      = res_reg.tx_last;

    a_tx_only_in_transmit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_next.event_res == EV_TX_BYTE) |-> (phase_reg == PH_TRANSMIT))
        else $error("Reply byte produced outside the transmit phase.");

    a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_next.event_res == EV_TX_BYTE && res_next.tx_last)
        |=> (phase_reg == PH_WAIT_FIRST))
        else $error("Final reply byte did not return the block to receive.");

    a_reply_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TRANSMIT) |-> (len_reg <= MAX_REPLY))
        else $error("Reply longer than permitted is being sent.");

    a_rx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= CntW'(FRAME_BYTES + 1))
        else $error("Received byte count beyond its saturation value.");

endmodule

`default_nettype wire

[bench/mbrtu_checker.sv]
// Scoreboard for the Modbus RTU slave frame engine: predicts each result beat and compares.
// Depends on mbrtu_pkg and the channel interfaces in mbrtu_if.sv; holds a small bench package.
`timescale 1ns / 100ps

package mbrtu_bench_pkg;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

module mbrtu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mbrtu_req_if        req,
    mbrtu_rsp_if        rsp,
    output int          fail_count,
    output int          pending
);
    import mbrtu_pkg::*;
    import mbrtu_bench_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_RX, PH_AWAIT, PH_TX} phase_t;

    logic [7:0]  own_addr;
    logic [15:0] answer_tmo;
    logic [7:0]  rx_mem [256];
    logic [7:0]  tx_mem [256];
    int          rx_n;
    int          tx_len;
    int          tx_pos;
    int          wait_left;
    phase_t      phase;
    logic [15:0] base_addr;
    logic [7:0]  fn_held;
    result_t     expected_q [$];
    result_t     want;

    function automatic int rx_byte(input int i);
        int kept;
        kept = (rx_n < 256) ? rx_n : 256;
        return (i < kept && i < 256) ? rx_mem[i] : 0;
    endfunction

    function automatic int rx_word(input int i);
        return (rx_byte(i) << 8) | rx_byte(i + 1);
    endfunction

    function automatic logic [15:0] span_crc(input bit from_tx, input int len);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < len && i < 256; i++)
            c = crc16_step(c, from_tx ? tx_mem[i] : rx_mem[i]);
        return c;
    endfunction

    task automatic take_byte(input logic [7:0] v);
        if (rx_n < 256)
        begin
            rx_mem[rx_n] = v;
            rx_n++;
        end
        else
            rx_n = 257;
    endtask

    function automatic bit accept_frame(inout result_t r);
        int n;
        logic [15:0] c;
        logic [7:0] fn;
        n = rx_n;
        if (n > 256 || n < MIN_FRAME)
            return 0;
        if (rx_byte(0) != own_addr && rx_byte(0) != BROADCAST_ADDR)
            return 0;
        c = span_crc(0, n - 2);
        if (rx_byte(n - 2) != c[7:0] || rx_byte(n - 1) != c[15:8])
            return 0;
        fn = 8'(rx_byte(1));
        tx_mem[0] = own_addr;
        tx_mem[1] = fn;
        if (fn == FN_READ || fn == FN_READ_WRITE)
        begin
            r.read_start = 16'(rx_word(2));
            r.read_count = 8'(rx_word(4));
            if (fn == FN_READ_WRITE)
            begin
                r.write_start = 16'(rx_word(6));
                r.write_count = 8'(rx_word(8));
            end
            tx_mem[2] = {r.read_count[6:0], 1'b0};
            tx_len = 3;
            base_addr = r.read_start;
            r.request_kind = (fn == FN_READ) ? KIND_READ : KIND_READ_WRITE;
        end
        else if (fn == FN_WRITE_SINGLE || fn == FN_WRITE_MULTI)
        begin
            r.write_start = 16'(rx_word(2));
            r.write_count = (fn == FN_WRITE_SINGLE) ? 8'd1 : 8'(rx_word(4));
            for (int i = 2; i < 6; i++)
                tx_mem[i] = 8'(rx_byte(i));
            tx_len = 6;
            r.request_kind = (fn == FN_WRITE_SINGLE) ? KIND_WRITE_SINGLE : KIND_WRITE_MULTI;
        end
        else
            return 0;
        fn_held = fn;
        r.event_res = EV_REQUEST;
        return 1;
    endfunction

    task automatic predict(input logic [2:0] c, input logic [7:0] bv, input logic [15:0] ra,
                           input logic [15:0] rd, input logic rdy, output result_t r);
        int k;
        logic [15:0] crc;
        r = '0;
        case (c)
            CMD_RX_BYTE:
            begin
                if (phase == PH_IDLE)
                begin
                    rx_n = 0;
                    take_byte(bv);
                    phase = PH_RX;
                end
                else if (phase == PH_RX)
                    take_byte(bv);
            end
            CMD_GAP:
            begin
                if (phase == PH_RX)
                begin
                    if (accept_frame(r))
                    begin
                        wait_left = answer_tmo;
                        phase = PH_AWAIT;
                    end
                    else
                    begin
                        r = '0;
                        phase = PH_IDLE;
                    end
                end
            end
            CMD_PUSH:
            begin
                if (phase != PH_AWAIT || ra < base_addr
                    || (fn_held != FN_READ && fn_held != FN_READ_WRITE))
                    r.event_res = EV_BAD_PUSH;
                else
                begin
                    k = (3 + 2 * (ra - base_addr)) & 255;
                    tx_mem[k] = rd[15:8];
                    tx_mem[(k + 1) & 255] = rd[7:0];
                    tx_len = (tx_len + 2 > 511) ? 511 : tx_len + 2;
                end
            end
            CMD_ANSWER:
            begin
                if (phase == PH_AWAIT)
                begin
                    if (tx_len > MAX_REPLY)
                    begin
                        r.event_res = EV_DROP;
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        crc = span_crc(1, tx_len);
                        tx_mem[tx_len & 255] = crc[7:0];
                        tx_mem[(tx_len + 1) & 255] = crc[15:8];
                        tx_len += 2;
                        tx_pos = 0;
                        phase = PH_TX;
                    end
                end
            end
            CMD_TICK:
            begin
                if (phase == PH_AWAIT)
                begin
                    if (wait_left <= 1)
                    begin
                        wait_left = 0;
                        r.event_res = EV_DROP;
                        phase = PH_IDLE;
                    end
                    else
                        wait_left--;
                end
                else if (phase == PH_TX && rdy)
                begin
                    r.event_res = EV_TX_BYTE;
                    r.tx_byte = tx_mem[tx_pos & 255];
                    if (tx_pos + 1 >= tx_len)
                    begin
                        r.tx_last = 1'b1;
                        phase = PH_IDLE;
                    end
                    tx_pos = (tx_pos + 1) & 255;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr = SLAVE_ADDR_RESET;
            answer_tmo = TIMEOUT_RESET;
            foreach (rx_mem[i])
            begin
                rx_mem[i] = '0;
                tx_mem[i] = '0;
            end
            rx_n = 0;
            tx_len = 0;
            tx_pos = 0;
            wait_left = 0;
            phase = PH_IDLE;
            base_addr = '0;
            fn_held = '0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("event_res", want.event_res, rsp.event_res);
                    compare_field("request_kind", want.request_kind, rsp.request_kind);
                    compare_field("read_start", want.read_start, rsp.read_start);
                    compare_field("read_count", want.read_count, rsp.read_count);
                    compare_field("write_start", want.write_start, rsp.write_start);
                    compare_field("write_count", want.write_count, rsp.write_count);
                    compare_field("tx_byte", want.tx_byte, rsp.tx_byte);
                    compare_field("tx_last", want.tx_last, rsp.tx_last);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SLAVE_ADDR)
                    own_addr = cfg_data[7:0];
                else if (cfg_index == CFG_TIMEOUT)
                    answer_tmo = cfg_data;
            end
            if (req.valid && req.ready)
            begin
                predict(req.cmd, req.byte_value, req.reg_addr, req.reg_data, req.tx_ready, want);
                expected_q.push_back(want);
            end
            pending = expected_q.size();
        end
    end

endmodule

[bench/tb.sv]
// Top of the bench for the Modbus RTU slave frame engine: clock, reset, stimulus and verdict.
// Depends on mbrtu_pkg, mbrtu_if.sv, the frame engine RTL and mbrtu_checker.sv.
`timescale 1ns / 100ps

module tb;
    import mbrtu_pkg::*;
    import mbrtu_bench_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          n_items;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          quiet_cycles;
    int          hold_left;
    bit          hold_go;
    bit          hold_done;
    logic [7:0]  addr_now;
    logic [15:0] tmo_now;
    logic [7:0]  frame_q [$];

    mbrtu_req_if req_ch();
    mbrtu_rsp_if rsp_ch();

    modbus_rtu_slave_frame_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    mbrtu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic put(input logic [2:0] c, input logic [7:0] bv, input logic [15:0] ra,
                       input logic [15:0] rd, input logic rdy);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= c;
        req_ch.byte_value <= bv;
        req_ch.reg_addr <= ra;
        req_ch.reg_data <= rd;
        req_ch.tx_ready <= rdy;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_items++;
    endtask

    task automatic put_cmd(input logic [2:0] c, input logic rdy);
        put(c, 8'($urandom), 16'($urandom), 16'($urandom), rdy);
    endtask

    task automatic send_frame(input bit bad_crc);
        logic [15:0] crc;
        crc = 16'hFFFF;
        foreach (frame_q[i])
        begin
            crc = crc16_step(crc, frame_q[i]);
            put(CMD_RX_BYTE, frame_q[i], 16'($urandom), 16'($urandom), 1'($urandom));
        end
        put(CMD_RX_BYTE, crc[7:0] ^ (bad_crc ? 8'h5A : 8'h00), 16'($urandom), 16'($urandom),
            1'($urandom));
        put(CMD_RX_BYTE, crc[15:8], 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic exchange();
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] cnt;
        int          m;
        int          pick;
        int          wrap_o;
        int          ticks;
        int          rlen;
        bit          is_read;
        put_cmd(CMD_GAP, 1'($urandom));
        if ($urandom_range(0, 39) == 0)
        begin
            repeat (258) put(CMD_RX_BYTE, 8'($urandom), 16'($urandom), 16'($urandom),
                             1'($urandom));
            put_cmd(CMD_GAP, 1'($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        fn = (pick < 24) ? FN_READ : (pick < 48) ? FN_READ_WRITE :
             (pick < 68) ? FN_WRITE_SINGLE : (pick < 88) ? FN_WRITE_MULTI : 8'($urandom);
        pick = $urandom_range(0, 9);
        start = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65000));
        cnt = 16'($urandom);
        frame_q.delete();
        pick = $urandom_range(0, 99);
        frame_q.push_back((pick < 70) ? addr_now : (pick < 85) ? BROADCAST_ADDR : 8'($urandom));
        frame_q.push_back(fn);
        frame_q.push_back(start[15:8]);
        frame_q.push_back(start[7:0]);
        frame_q.push_back(cnt[15:8]);
        frame_q.push_back(cnt[7:0]);
        repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0)
            frame_q = frame_q[0:$urandom_range(1, 5)];
        send_frame($urandom_range(0, 9) == 0);
        put_cmd(CMD_GAP, 1'($urandom));

        is_read = (fn == FN_READ || fn == FN_READ_WRITE);
        m = 0;
        if (is_read)
        begin
            pick = $urandom_range(0, 99);
            m = (pick < 3) ? 125 : (pick < 5) ? 126 : (pick < 10) ? 0 : $urandom_range(1, 8);
            if (m > 65536 - start)
                m = 65536 - start;
        end
        wrap_o = -1;
        if (m > 0 && $urandom_range(0, 3) == 0)
        begin
            wrap_o = $urandom_range(0, m - 1);
            if (start + wrap_o + 128 > 65535)
                wrap_o = -1;
        end
        for (int o = 0; o < m; o++)
            put(CMD_PUSH, 8'($urandom), 16'(start + o + ((o == wrap_o) ? 128 : 0)),
                16'($urandom), 1'($urandom));
        if ($urandom_range(0, 4) == 0 && start > 0)
            put(CMD_PUSH, 8'($urandom), start - 16'd1, 16'($urandom), 1'($urandom));
        if (!is_read && $urandom_range(0, 3) == 0)
            put_cmd(CMD_PUSH, 1'($urandom));
        ticks = (tmo_now <= 8) ? $urandom_range(0, tmo_now + 1) : 0;
        repeat (ticks) put_cmd(CMD_TICK, 1'($urandom));
        put_cmd(CMD_ANSWER, 1'($urandom));
        rlen = is_read ? 5 + 2 * m : 8;
        repeat (rlen)
        begin
            if ($urandom_range(0, 7) == 0)
                put_cmd(CMD_TICK, 1'b0);
            put_cmd(CMD_TICK, 1'b1);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) put_cmd(3'($urandom_range(0, 7)), 1'($urandom));
    endtask

    initial
    begin
        logic [7:0]  addr_set [4];
        logic [15:0] tmo_set [4];
        int          idle_set [4];
        int          stall_set [4];
        int          goal;
        addr_set = '{8'd1, 8'hFF, 8'h00, BROADCAST_ADDR};
        tmo_set = '{16'd1500, 16'd3, 16'hFFFF, 16'd1};
        idle_set = '{0, 46, 0, 37};
        stall_set = '{0, 0, 46, 37};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.byte_value = '0;
        req_ch.reg_addr = '0;
        req_ch.reg_data = '0;
        req_ch.tx_ready = 1'b0;
        hold_go = 0;
        n_items = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        quiet_cycles = 0;
        addr_now = SLAVE_ADDR_RESET;
        tmo_now = TIMEOUT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        put(CMD_PUSH, 8'h00, 16'h0000, 16'hFFFF, 1'b0);
        put(CMD_ANSWER, 8'hFF, 16'hFFFF, 16'h0000, 1'b1);
        put(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 1'b1);
        put(3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        frame_q = '{8'h01, FN_WRITE_SINGLE, 8'h00, 8'h10, 8'hFF, 8'hFF};
        send_frame(0);
        put_cmd(CMD_GAP, 1'b0);
        put_cmd(CMD_ANSWER, 1'b0);
        repeat (8) put_cmd(CMD_TICK, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            addr_now = addr_set[ph];
            tmo_now = tmo_set[ph];
            write_cfg(CFG_SLAVE_ADDR, {8'h00, addr_now});
            write_cfg(CFG_TIMEOUT, tmo_now);
            tx_idle_pct = idle_set[ph];
            rx_stall_pct = stall_set[ph];
            goal = n_items + PHASE_ITEMS;
            while (n_items < goal)
            begin
                exchange();
                if (ph == 1 && n_items > goal - PHASE_ITEMS / 2)
                    hold_go = 1;
                if (ph == 2 && $urandom_range(0, 19) == 0)
                    drain();
            end
        end
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
